### sv/utda_pkg.sv
// ----------------------------------------------------------------------------
// utda_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package utda_pkg;

   // Bits folded into the BCD register per conversion cycle
   localparam int BITS_PER_STEP = 4;

   // ASCII code of '0', cut to the six bits of the digit port
   localparam logic [5:0] ASCII_ZERO = 6'd48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_FIND,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;     // capture a new value, clear BCD
      logic shift;    // fold the next value bits into BCD (double dabble)
      logic find;     // locate most significant nonzero digit
      logic advance;  // move to next lower digit
   } cmd_type;

   typedef struct packed {
      logic conv_done;  // current shift cycle is the last one
      logic ptr_zero;   // digit pointer at least significant digit
   } status_type;

endpackage

### sv/utda_ctrl.sv
// ----------------------------------------------------------------------------
// utda_ctrl
// Sequencer: load, convert, find leading digit, emit digits.
// ----------------------------------------------------------------------------
module utda_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  utda_pkg::status_type  status,
   output utda_pkg::cmd_type     cmd
);
   import utda_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (status.conv_done) state_in = ST_FIND;
         end
         ST_FIND: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready && status.ptr_zero) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CONV: begin
            cmd.shift = 1'b1;
         end
         ST_FIND: begin
            cmd.find = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

### sv/utda_dpath.sv
// ----------------------------------------------------------------------------
// utda_dpath
// Double-dabble BCD conversion and digit selection.
// ----------------------------------------------------------------------------
module utda_dpath #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                    clock,
   input  logic [VALUE_WIDTH-1:0]  req_value,
   input  utda_pkg::cmd_type       cmd,
   output utda_pkg::status_type    status,
   output logic [5:0]              digit_char
);
   import utda_pkg::*;

   localparam int STEPS  = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int PW     = STEPS * BITS_PER_STEP;
   localparam int DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BW     = DIGITS * 4;
   localparam int CW     = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int PTRW   = $clog2(DIGITS);

   logic [PW-1:0]   value_ff, value_in;
   logic [BW-1:0]   bcd_ff, bcd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [PTRW-1:0] ptr_ff, ptr_in;

   logic [BW-1:0]   bcd_step;
   logic [PTRW-1:0] msd_idx;

   // Four shift-and-add-3 passes, MSB of the value first
   always_comb begin
      logic [BW-1:0] acc;
      acc = bcd_ff;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (acc[d*4 +: 4] >= 4'd5) acc[d*4 +: 4] = acc[d*4 +: 4] + 4'd3;
         end
         acc = {acc[BW-2:0], value_ff[PW-1-s]};
      end
      bcd_step = acc;
   end

   // Highest nonzero digit; zero value points at digit 0
   always_comb begin
      msd_idx = '0;
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_ff[d*4 +: 4] != 4'd0) msd_idx = PTRW'(d);
      end
   end

   always_comb begin
      value_in = value_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      ptr_in   = ptr_ff;
      if (cmd.load) begin
         value_in = PW'(req_value);
         bcd_in   = '0;
         cnt_in   = CW'(STEPS - 1);
      end
      if (cmd.shift) begin
         value_in = value_ff << BITS_PER_STEP;
         bcd_in   = bcd_step;
         cnt_in   = cnt_ff - 1'b1;
      end
      if (cmd.find) begin
         ptr_in = msd_idx;
      end
      if (cmd.advance) begin
         ptr_in = ptr_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      bcd_ff   <= bcd_in;
      cnt_ff   <= cnt_in;
      ptr_ff   <= ptr_in;
   end

   assign status.conv_done = (cnt_ff == '0);
   assign status.ptr_zero  = (ptr_ff == '0);
   assign digit_char       = ASCII_ZERO + {2'b00, bcd_ff[ptr_ff*4 +: 4]};

endmodule

### sv/unsigned_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// unsigned_to_decimal_ascii
// Unsigned binary number to decimal ASCII digit stream.
// ----------------------------------------------------------------------------
// Each req transaction carries one VALUE_WIDTH-bit unsigned number; the block
// answers with its decimal text as a run of rsp transactions, one ASCII digit
// ('0'..'9') each, most significant first, with rsp_last set on the final
// digit. Zero gives a single '0'; no leading zeros are sent. One number is
// handled at a time: after acceptance the double-dabble datapath folds four
// value bits into a BCD register per cycle until all value bits are in, a
// find state then locates the leading digit, and digits go out one per cycle
// while rsp_ready is high. req_ready returns high once the last digit
// transaction completes.
// ----------------------------------------------------------------------------
module unsigned_to_decimal_ascii #(
   parameter int VALUE_WIDTH = 64   // 8..64
) (
   input  logic                   clock,
   input  logic                   reset,
   // input channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [5:0]             rsp_digit_char,
   output logic                   rsp_last
);
   import utda_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer: owns the handshakes, steps the datapath
   utda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: value shifter, BCD register, digit pointer
   utda_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .req_value  (req_value),
      .cmd        (cmd),
      .status     (status),
      .digit_char (rsp_digit_char)
   );

   // pointer at digit 0 marks the least significant digit
   assign rsp_last = status.ptr_zero;

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
// A queue of numbers is filled at time zero: a directed set first, then random
// numbers spread over every decimal length. A falling-edge driver offers them
// on the req channel with random gaps. A rising-edge monitor turns each
// accepted number into its expected digit transactions and checks every rsp
// transaction against the oldest one. The receiver drops rsp_ready at random.
// Once in the run it holds off for a long stretch so that the block backs up
// and stalls its input.
// ----------------------------------------------------------------------------
module tb;
   import utda_pkg::*;

   localparam int VALUE_WIDTH   = 64;
   localparam int MAX_DIGITS    = 20;
   localparam int RANDOM_ITEMS  = 212;
   localparam int HOLD_AFTER    = 150;   // digits seen before the long hold-off
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 60;    // a bit more than one full conversion

   typedef struct {
      logic [VALUE_WIDTH-1:0] number;
      int unsigned            gap;       // idle cycles before it is offered
   } number_item_type;

   typedef struct packed {
      logic [5:0] digit_char;
      logic       last;
   } digit_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [VALUE_WIDTH-1:0] req_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [5:0]             rsp_digit_char;
   logic                   rsp_last;

   number_item_type values_to_send[$];
   digit_item_type  digits_due[$];

   // driver state
   number_item_type staged;
   bit           staged_ok = 1'b0;
   int unsigned  offers_made = 0;
   int unsigned  offers_taken = 0;

   // receiver state
   int unsigned  digits_seen = 0;
   int unsigned  rx_stall_left = 0;
   int unsigned  rx_hold_left = 0;
   int unsigned  rx_cycle = 0;
   bit           rx_calm = 1'b0;
   bit           hold_done = 1'b0;

   bit           failed = 1'b0;

   unsigned_to_decimal_ascii #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one; none in a calm stretch.
   function automatic int unsigned pick_gap(input bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic void add_number(input logic [VALUE_WIDTH-1:0] number, input bit calm);
      number_item_type item;
      item.number = number;
      item.gap    = pick_gap(calm);
      values_to_send.push_back(item);
   endfunction

   function automatic logic [63:0] power_of_ten(input int unsigned exponent);
      logic [63:0] p;
      p = 64'd1;
      repeat (exponent) p = p * 64'd10;
      return p;
   endfunction

   // Random numbers spread over all decimal lengths, with the edges of each
   // length (10^k - 1, 10^k, 10^k + 1) hit often.
   function automatic logic [63:0] random_number();
      logic [63:0] full;
      int unsigned nbits;
      full  = {$urandom, $urandom};
      nbits = $urandom_range(1, 64);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return (nbits == 64) ? full : full & ((64'd1 << nbits) - 64'd1);
         5, 6:          return full;
         7:             return power_of_ten($urandom_range(0, 19)) + 64'($urandom_range(0, 2))
                               - 64'd1;
         8:             return 64'($urandom_range(0, 999));
         default:       return (nbits == 64) ? '1 : (64'd1 << nbits) - 64'd1;
      endcase
   endfunction

   // Expected digit transactions for one number: peel off digits least
   // significant first, then queue them most significant first.
   function automatic void queue_decimal_text(input logic [VALUE_WIDTH-1:0] number);
      logic [63:0] rest;
      logic [3:0]  lsd_first[MAX_DIGITS];
      int          count;
      digit_item_type item;
      rest  = 64'(number);
      count = 0;
      do begin
         lsd_first[count] = 4'(rest % 64'd10);
         rest  = rest / 64'd10;
         count = count + 1;
      end while (rest != 0 && count < MAX_DIGITS);
      for (int k = count - 1; k >= 0; k--) begin
         item.digit_char = ASCII_ZERO + 6'(lsd_first[k]);
         item.last       = (k == 0);
         digits_due.push_back(item);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Driver: falling edge. offers_taken catches up with offers_made when the
   // monitor sees the transaction accepted, which frees req_valid. A follow-on
   // number with no gap keeps req_valid high, so it is written once per edge.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      logic next_valid;
      next_valid = req_valid && (offers_taken != offers_made);
      if (!reset && !next_valid) begin
         if (!staged_ok && values_to_send.size() != 0) begin
            staged    = values_to_send.pop_front();
            staged_ok = 1'b1;
         end
         if (staged_ok) begin
            if (staged.gap != 0) begin
               staged.gap = staged.gap - 1;
            end else begin
               next_valid  = 1'b1;
               req_value  <= staged.number;
               offers_made = offers_made + 1;
               staged_ok   = 1'b0;
            end
         end
      end
      req_valid <= next_valid;
   end

   // ------------------------------------------------------------------------
   // Receiver: falling edge. Random stalls, calm windows, and a single long
   // hold-off once enough digits have gone by.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle = rx_cycle + 1;
         if (rx_cycle % 256 == 0)
            rx_calm = ($urandom_range(0, 3) == 0);
         if (rx_hold_left != 0) begin
            rx_hold_left = rx_hold_left - 1;
            rsp_ready   <= 1'b0;
         end else if (!hold_done && digits_seen >= HOLD_AFTER) begin
            hold_done    = 1'b1;
            rx_hold_left = HOLD_CYCLES - 1;
            rsp_ready   <= 1'b0;
         end else if (rx_stall_left != 0) begin
            rx_stall_left = rx_stall_left - 1;
            rsp_ready    <= 1'b0;
         end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
            rx_stall_left = pick_gap(1'b0);
            if (rx_stall_left != 0)
               rx_stall_left = rx_stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: rising edge. Accepted numbers feed the expected digit queue;
   // each digit transaction is checked against its head.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      digit_item_type want;
      if (!reset && req_valid && req_ready) begin
         queue_decimal_text(req_value);
         offers_taken <= offers_taken + 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         digits_seen = digits_seen + 1;
         if (digits_due.size() == 0) begin
            $error("unexpected digit transaction: digit_char %0d, last %0b",
                   rsp_digit_char, rsp_last);
            failed = 1'b1;
         end else begin
            want = digits_due.pop_front();
            if (rsp_digit_char !== want.digit_char) begin
               $error("digit_char: expected %0d, actual %0d", want.digit_char, rsp_digit_char);
               failed = 1'b1;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_last);
               failed = 1'b1;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      bit tx_calm;

      // directed: zero, one digit, length boundaries, widest values, and
      // alternating patterns so that every input bit is seen at both levels
      add_number(64'd0, 1'b0);
      add_number(64'd1, 1'b0);
      add_number(64'd9, 1'b0);
      add_number(64'd10, 1'b0);
      add_number(64'd99, 1'b0);
      add_number(64'd100, 1'b0);
      add_number(64'd12345, 1'b0);
      add_number(64'd1234567890, 1'b0);
      add_number(64'h0000_0000_FFFF_FFFF, 1'b0);
      add_number(64'h0000_0001_0000_0000, 1'b0);
      add_number(64'd999999999999999999, 1'b0);
      add_number(64'd1000000000000000000, 1'b0);
      add_number(64'd9999999999999999999, 1'b0);
      add_number(64'd10000000000000000000, 1'b0);
      add_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      add_number(64'h8000_0000_0000_0000, 1'b0);
      add_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      add_number(64'h5555_5555_5555_5555, 1'b0);
      add_number(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
      add_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);

      // random, sender calm in some stretches of 20 numbers
      tx_calm = 1'b0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 20 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
         add_number(random_number(), tx_calm);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (values_to_send.size() != 0 || staged_ok || offers_taken != offers_made)
         @(posedge clock);
      while (digits_due.size() != 0)
         @(posedge clock);
      // catch stray digits after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (!failed)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

### unsigned_to_decimal_ascii.f
sv/utda_pkg.sv
sv/utda_ctrl.sv
sv/utda_dpath.sv
sv/unsigned_to_decimal_ascii.sv
sim/tb.sv
